@@ src/salct_pkg.sv @@
// shared types, constants and helpers of the cache tag store
package salct_pkg;

  localparam int NUM_SET_ROWS = 64;
  localparam int NUM_WAYS     = 4;
  localparam int LINE_BYTES   = 64;
  localparam int ADDR_BITS    = 64;

  localparam int OFFSET_BITS = $clog2(LINE_BYTES);
  localparam int SET_BITS    = $clog2(NUM_SET_ROWS);
  localparam int WAY_BITS    = $clog2(NUM_WAYS);
  localparam int TAG_BITS    = ADDR_BITS - OFFSET_BITS - SET_BITS;

  localparam int IN_TDATA_W  = ADDR_BITS;
  localparam int OUT_TDATA_W = 8;

  typedef logic [SET_BITS-1:0] set_t;
  typedef logic [WAY_BITS-1:0] way_t;
  typedef logic [TAG_BITS-1:0] tag_t;

  typedef logic [NUM_WAYS-1:0][TAG_BITS-1:0] tag_row_t;

  // per-set status: valid and dirty per way, recency rank per way (0 = most recent)
  typedef struct packed {
    logic [NUM_WAYS-1:0]               valid;
    logic [NUM_WAYS-1:0]               dirty;
    logic [NUM_WAYS-1:0][WAY_BITS-1:0] rank;
  } meta_row_t;

  localparam int TAG_ROW_BITS  = NUM_WAYS * TAG_BITS;
  localparam int META_ROW_BITS = 2 * NUM_WAYS + NUM_WAYS * WAY_BITS;

  // outcome of one lookup
  typedef struct packed {
    logic hit;
    logic dirty_evict;
    way_t way;
  } lookup_res_t;

  // status of a set that was never written: all invalid, rank equals way
  function automatic meta_row_t meta_reset_row();
    meta_row_t r;
    r.valid = '0;
    r.dirty = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      r.rank[w] = way_t'(w);
    end
    return r;
  endfunction

endpackage

@@ src/salct_ram.sv @@
// generic single-port-write, registered-read synchronous ram
module salct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/salct_meta_store.sv @@
// per-set valid/dirty/rank store with row-written flags for reset
module salct_meta_store (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 we,
  input  salct_pkg::set_t      waddr,
  input  salct_pkg::meta_row_t wdata,
  input  logic                 re,
  input  salct_pkg::set_t      raddr,
  output salct_pkg::meta_row_t rdata
);
  import salct_pkg::*;

  logic [META_ROW_BITS-1:0] ram_rdata;
  logic [NUM_SET_ROWS-1:0]  row_vld_r;
  logic                     rd_vld_r;

  salct_ram #(
    .WIDTH (META_ROW_BITS),
    .DEPTH (NUM_SET_ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // one flag per set: row has been written since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (we) begin
      row_vld_r[waddr] <= 1'b1;
    end
  end

  // flag read alongside the ram so both land in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (re) begin
      rd_vld_r <= row_vld_r[raddr];
    end
  end

  // unwritten rows read as the reset status
  assign rdata = rd_vld_r ? meta_row_t'(ram_rdata) : meta_reset_row();

endmodule

@@ src/salct_repl.sv @@
// hit detection, victim choice and lru rank update for one set
module salct_repl (
  input  salct_pkg::tag_row_t    tag_row,
  input  salct_pkg::meta_row_t   meta_row,
  input  salct_pkg::tag_t        tag,
  input  logic                   wr,
  output salct_pkg::lookup_res_t res,
  output salct_pkg::meta_row_t   meta_nxt,
  output salct_pkg::tag_row_t    tag_row_nxt
);
  import salct_pkg::*;

  logic hit;
  way_t hit_way;
  logic any_inv;
  way_t inv_way;
  way_t lru_way;
  way_t worst;
  way_t sel;
  way_t old_rank;

  // tag compare, lowest matching way wins
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (meta_row.valid[w] && (tag_row[w] == tag)) begin
        hit     = 1'b1;
        hit_way = way_t'(w);
      end
    end
  end

  // lowest invalid way
  always_comb begin
    any_inv = 1'b0;
    inv_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (!meta_row.valid[w]) begin
        any_inv = 1'b1;
        inv_way = way_t'(w);
      end
    end
  end

  // least recent way: lowest way holding the largest rank
  always_comb begin
    worst   = meta_row.rank[0];
    lru_way = '0;
    for (int w = 1; w < NUM_WAYS; w++) begin
      if (meta_row.rank[w] > worst) begin
        worst   = meta_row.rank[w];
        lru_way = way_t'(w);
      end
    end
  end

  assign sel      = hit ? hit_way : (any_inv ? inv_way : lru_way);
  assign old_rank = meta_row.rank[sel];

  // new status row: selected way moves to front, more recent ways age by one
  always_comb begin
    meta_nxt = meta_row;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if ((way_t'(w) != sel) && (meta_row.rank[w] < old_rank)) begin
        meta_nxt.rank[w] = way_t'(meta_row.rank[w] + 1'b1);
      end
    end
    meta_nxt.rank[sel]  = '0;
    meta_nxt.valid[sel] = 1'b1;
    meta_nxt.dirty[sel] = hit ? (meta_row.dirty[sel] | wr) : 1'b0;
  end

  // new tag row, written back on a fill only
  always_comb begin
    tag_row_nxt      = tag_row;
    tag_row_nxt[sel] = tag;
  end

  assign res.hit         = hit;
  assign res.dirty_evict = !hit && !any_inv && meta_row.dirty[lru_way];
  assign res.way         = sel;

endmodule

@@ src/set_assoc_lru_cache_tags_core.sv @@
// top level of the 4-way lru cache tag store
//
//  channel | dir | beat contents
//  --------+-----+------------------------------------------------------------
//  in_     | in  | tdata: address[63:0]; tuser: store flag
//  out_    | out | tdata: hit[0], dirty_evict[1], way_used[3:2], zero[7:4]
//
//  each access reads the set row from the tag and status rams, then compares,
//  picks the way and writes the row back; no new access is taken until then.
//  the lookup waits in place while the output register holds an untaken beat.
//  reset clears the per-set written flags at once; no clearing pass is needed.
module set_assoc_lru_cache_tags_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [salct_pkg::IN_TDATA_W-1:0]   in_tdata,   // address
  input  logic                               in_tuser,   // store flag
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [salct_pkg::OUT_TDATA_W-1:0]  out_tdata   // hit, dirty_evict, way_used
);
  import salct_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  state_t      state_r;
  tag_t        tag_r;
  set_t        set_r;
  logic        wr_r;
  logic        out_tvalid_r;
  lookup_res_t res_r;

  logic        in_acc;
  logic        out_free;
  logic        commit;
  set_t        in_set;
  tag_row_t    tag_row;
  tag_row_t    tag_row_nxt;
  meta_row_t   meta_row;
  meta_row_t   meta_nxt;
  lookup_res_t res;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_set    = in_tdata[OFFSET_BITS +: SET_BITS];
  assign out_free  = !out_tvalid_r || out_tready;
  assign commit    = (state_r == ST_LOOKUP) && out_free;

  // tag rows, written only on a fill
  salct_ram #(
    .WIDTH (TAG_ROW_BITS),
    .DEPTH (NUM_SET_ROWS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (commit && !res.hit),
    .waddr (set_r),
    .wdata (tag_row_nxt),
    .re    (in_acc),
    .raddr (in_set),
    .rdata (tag_row)
  );

  // status rows, written on every access
  salct_meta_store u_meta (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (commit),
    .waddr (set_r),
    .wdata (meta_nxt),
    .re    (in_acc),
    .raddr (in_set),
    .rdata (meta_row)
  );

  salct_repl u_repl (
    .tag_row     (tag_row),
    .meta_row    (meta_row),
    .tag         (tag_r),
    .wr          (wr_r),
    .res         (res),
    .meta_nxt    (meta_nxt),
    .tag_row_nxt (tag_row_nxt)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      // new beat loaded, or the held beat taken
      if (commit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= ST_LOOKUP;
            set_r   <= in_set;
            tag_r   <= in_tdata[OFFSET_BITS + SET_BITS +: TAG_BITS];
            wr_r    <= in_tuser;
          end
        end
        ST_LOOKUP: begin
          if (out_free) begin
            state_r <= ST_IDLE;
            res_r   <= res;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W - 2 - WAY_BITS){1'b0}}, res_r.way,
                       res_r.dirty_evict, res_r.hit};

endmodule

@@ tb/tb_set_assoc_lru_cache_tags_core.sv @@
// testbench of the lru cache tag store: directed and random accesses checked against a predictor
module tb_set_assoc_lru_cache_tags_core;
  import salct_pkg::*;

  localparam bit ACC_LOAD     = 1'b0;
  localparam bit ACC_STORE    = 1'b1;
  localparam int MAX_IDLE     = 12;
  localparam int TAIL_CYCLES  = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 10;
  localparam int RANDOM_ITEMS = 1050;
  localparam int CHUNK_ITEMS  = 150;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // predictor state: one tag row and one status row per set
  tag_row_t    pred_tags [NUM_SET_ROWS];
  meta_row_t   pred_meta [NUM_SET_ROWS];
  lookup_res_t expected_lookups[$];

  // idling control, pools for random traffic
  bit   tx_idle_en;
  bit   rx_idle_en;
  int   rx_hold;
  tag_t tag_pool [6];
  set_t set_pool [4];

  int errors;
  int cycle_cnt;
  int accesses_sent;
  int beats_checked;
  int hits_seen;
  int dirty_evicts_seen;

  set_assoc_lru_cache_tags_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               expected_lookups.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // move one way to the front of the recency order
  function automatic meta_row_t touch_way(meta_row_t row, way_t w);
    way_t old_rank;
    old_rank = row.rank[w];
    for (int i = 0; i < NUM_WAYS; i++) begin
      if (i != w && row.rank[i] < old_rank) row.rank[i] = way_t'(row.rank[i] + 1'b1);
    end
    row.rank[w] = '0;
    return row;
  endfunction

  // predict the lookup outcome of one access and update the predictor state
  function automatic lookup_res_t predict_lookup(logic [63:0] addr, bit wr);
    lookup_res_t res;
    set_t        s;
    tag_t        t;
    meta_row_t   row;
    way_t        victim;
    bit          found;
    s   = addr[OFFSET_BITS +: SET_BITS];
    t   = addr[OFFSET_BITS + SET_BITS +: TAG_BITS];
    row = pred_meta[s];
    res = '0;
    found = 1'b0;
    // hit search
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!found && row.valid[w] && pred_tags[s][w] == t) begin
        found = 1'b1;
        if (wr == ACC_STORE) row.dirty[w] = 1'b1;
        row = touch_way(row, way_t'(w));
        res.hit = 1'b1;
        res.way = way_t'(w);
      end
    end
    if (!found) begin
      // lowest invalid way first, else the least recent one
      victim = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
        if (!row.valid[w]) begin
          victim = way_t'(w);
          found  = 1'b1;
        end
      end
      if (!found) begin
        victim = '0;
        for (int w = 1; w < NUM_WAYS; w++) begin
          if (row.rank[w] > row.rank[victim]) victim = way_t'(w);
        end
        res.dirty_evict = row.dirty[victim];
      end
      pred_tags[s][victim] = t;
      row.valid[victim] = 1'b1;
      row.dirty[victim] = 1'b0;
      row = touch_way(row, victim);
      res.way = victim;
    end
    pred_meta[s] = row;
    return res;
  endfunction

  function automatic logic [63:0] make_addr(tag_t t, set_t s, logic [OFFSET_BITS-1:0] off);
    return {t, s, off};
  endfunction

  // send one access beat; called and returns at a falling edge
  task automatic send_access(logic [63:0] addr, bit wr);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= addr;
    in_tuser  <= wr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_lookups.push_back(predict_lookup(addr, wr));
    accesses_sent++;
    @(negedge clk);
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
    in_tdata  <= {$urandom, $urandom};
    in_tuser  <= 1'($urandom_range(0, 1));
  endtask

  // result side: per beat stall drawn when a beat is taken
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    lookup_res_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      beats_checked++;
      rx_hold = rx_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
      if (out_tdata[0]) hits_seen++;
      if (out_tdata[1]) dirty_evicts_seen++;
      if (expected_lookups.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result beat %h at cycle %0d", out_tdata, cycle_cnt);
      end else begin
        exp_res = expected_lookups.pop_front();
        if (out_tdata[0] !== exp_res.hit || out_tdata[1] !== exp_res.dirty_evict ||
            out_tdata[3:2] !== exp_res.way || out_tdata[7:4] !== 4'b0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("mismatch at beat %0d: exp hit=%b dirty=%b way=%0d, got tdata=%h",
                     beats_checked, exp_res.hit, exp_res.dirty_evict, exp_res.way,
                     out_tdata);
        end
      end
    end
  end

  // lowest and all-ones addresses, a store hit on the all-ones line, a store miss to tag zero
  task automatic test_corner_addresses();
    send_access(64'h0, ACC_LOAD);
    send_access({64{1'b1}}, ACC_LOAD);
    send_access({64{1'b1}}, ACC_STORE);
    send_access(make_addr('0, '1, '0), ACC_STORE);
  endtask

  // fill the remaining ways, evict a dirty line, then a store-miss line that stays clean
  task automatic test_fill_and_evict();
    set_t s;
    s = '1;
    send_access(make_addr(tag_t'(1), s, 6'h15), ACC_LOAD);
    send_access(make_addr(tag_t'(2), s, 6'h2a), ACC_LOAD);
    send_access(make_addr(tag_t'(3), s, 6'h00), ACC_STORE);
    send_access(make_addr(tag_t'(4), s, 6'h3f), ACC_LOAD);
    send_access(make_addr(tag_t'(4), s, 6'h01), ACC_STORE);
    send_access(make_addr(tag_t'(5), s, 6'h02), ACC_LOAD);
    send_access(make_addr(tag_t'(6), s, 6'h03), ACC_LOAD);
    send_access(make_addr(tag_t'(7), s, 6'h04), ACC_LOAD);
    send_access(make_addr(tag_t'(8), s, 6'h05), ACC_LOAD);
    send_access(make_addr(tag_t'(2), s, 6'h06), ACC_LOAD);
  endtask

  // back-to-back accesses to one set with no idling on either side
  task automatic test_same_set_burst();
    set_t s;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    s = set_t'(6'h2a);
    send_access(make_addr(tag_t'(52'h5_5555_5555_5555), s, '1), ACC_STORE);
    send_access(make_addr(tag_t'(52'h5_5555_5555_5555), s, '0), ACC_STORE);
    send_access(make_addr(tag_t'(52'ha_aaaa_aaaa_aaaa), s, '0), ACC_LOAD);
    send_access(make_addr(tag_t'(52'ha_aaaa_aaaa_aaaa), s, '0), ACC_STORE);
    send_access(make_addr(tag_t'(52'h1), s, '0), ACC_LOAD);
    send_access(make_addr(tag_t'(52'h2), s, '0), ACC_LOAD);
    send_access(make_addr(tag_t'(52'h3), s, '0), ACC_LOAD);
    send_access(make_addr(tag_t'(52'h5_5555_5555_5555), s, '0), ACC_LOAD);
  endtask

  // random traffic: mostly a few sets and tags so hits and evictions are common
  task automatic test_random_traffic();
    int          chunk;
    int          r;
    logic [63:0] addr;
    chunk = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % CHUNK_ITEMS == 0) begin
        tx_idle_en = chunk[0] ^ chunk[1];
        rx_idle_en = ~chunk[1];
        foreach (tag_pool[k]) tag_pool[k] = tag_t'({$urandom, $urandom});
        foreach (set_pool[k]) set_pool[k] = set_t'($urandom);
        tag_pool[0] = '1;
        tag_pool[1] = '0;
        chunk++;
      end
      r = $urandom_range(0, 99);
      if (r < 70)
        addr = make_addr(tag_pool[$urandom_range(0, 5)], set_pool[$urandom_range(0, 3)],
                         OFFSET_BITS'($urandom));
      else if (r < 85)
        addr = make_addr(tag_pool[$urandom_range(0, 5)], set_t'($urandom),
                         OFFSET_BITS'($urandom));
      else
        addr = {$urandom, $urandom};
      send_access(addr, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    errors            = 0;
    cycle_cnt         = 0;
    accesses_sent     = 0;
    beats_checked     = 0;
    hits_seen         = 0;
    dirty_evicts_seen = 0;
    rx_hold           = 0;
    tx_idle_en        = 1'b1;
    rx_idle_en        = 1'b1;
    out_tready        = 1'b0;
    in_tvalid         = 1'b0;
    in_tdata          = '0;
    in_tuser          = ACC_LOAD;
    rst_n             = 1'b0;
    for (int s = 0; s < NUM_SET_ROWS; s++) begin
      pred_tags[s] = '0;
      pred_meta[s] = meta_reset_row();
    end
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_corner_addresses();
    test_fill_and_evict();
    test_same_set_burst();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_random_traffic();
    stop_sending();

    // drain, then allow for the pipeline
    while (expected_lookups.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_lookups.size() != 0) errors++;

    $display("%0d accesses sent, %0d results checked", accesses_sent, beats_checked);
    $display("%0d hits, %0d dirty evictions, %0d mismatches", hits_seen, dirty_evicts_seen,
             errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/salct_pkg.sv
src/salct_ram.sv
src/salct_meta_store.sv
src/salct_repl.sv
src/set_assoc_lru_cache_tags_core.sv
tb/tb_set_assoc_lru_cache_tags_core.sv
